// ===== src/ugcb_pkg.sv =====
// Shared types and constants of the UART command bridge.
// Used by the front decoder, the job queue, the back sequencer and the top level.
package ugcb_pkg;

   localparam logic [7:0] CMD_IDENT = 8'h02;
   localparam logic [7:0] CMD_READ  = 8'hb9;
   localparam logic [7:0] CMD_WRITE = 8'hba;

   localparam int IDENT_LEN = 13;
   localparam int STEP_W    = 4;

   // frame position of the front decoder
   localparam logic [1:0] CNT_IDLE = 2'd0;
   localparam logic [1:0] CNT_HIGH = 2'd1;
   localparam logic [1:0] CNT_LOW  = 2'd2;

   typedef enum logic [1:0] {
      JOB_IDENT,
      JOB_READ,
      JOB_WRITE
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  value;   // inverted read word or inverted write value
   } job_type;

   typedef struct packed {
      logic    empty;
      job_type head;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_IDENT,
      BK_READ,
      BK_WRITE
   } back_state_type;

   // identification text; position IDENT_LEN is the terminating zero
   function automatic logic [7:0] ident_char(input logic [STEP_W-1:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h53;
         4'd1:    ch = 8'h4F;
         4'd2:    ch = 8'h33;
         4'd3:    ch = 8'h37;
         4'd4:    ch = 8'h31;
         4'd5:    ch = 8'h35;
         4'd6:    ch = 8'h2D;
         4'd7:    ch = 8'h31;
         4'd8:    ch = 8'h48;
         4'd9:    ch = 8'h2E;
         4'd10:   ch = 8'h31;
         4'd11:   ch = 8'h31;
         4'd12:   ch = 8'h30;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== src/ugcb_front.sv =====
// Front decoder: takes received bytes, tracks the write frame and turns
// commands into jobs for the queue. Depends on ugcb_pkg.
module ugcb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_ready,
   input  logic [7:0]         rx_byte,
   input  logic [15:0]        pins_b,
   input  logic [15:0]        pins_a,
   input  logic [15:0]        pins_e,
   output logic               push,
   output ugcb_pkg::job_type  push_job
);

   logic [1:0]  count_ff, count_in;
   logic [7:0]  data_high_ff, data_high_in;
   logic        take;
   logic [15:0] gathered;

   assign take = in_valid && in_ready;

   assign gathered = {pins_b[13:10], pins_a[7:4], pins_e[0], pins_b[9:3]};

   always_comb begin
      count_in       = count_ff;
      data_high_in   = data_high_ff;
      push           = 1'b0;
      push_job.kind  = ugcb_pkg::JOB_IDENT;
      push_job.value = 16'h0000;
      if (take) begin
         case (count_ff)
            ugcb_pkg::CNT_HIGH: begin
               data_high_in = rx_byte;
               count_in     = ugcb_pkg::CNT_LOW;
            end
            ugcb_pkg::CNT_LOW: begin
               count_in       = ugcb_pkg::CNT_IDLE;
               push           = 1'b1;
               push_job.kind  = ugcb_pkg::JOB_WRITE;
               push_job.value = ~{data_high_ff, rx_byte};
            end
            default: begin
               // idle (or the unused count code): byte is a command
               count_in = ugcb_pkg::CNT_IDLE;
               if (rx_byte == ugcb_pkg::CMD_IDENT) begin
                  push          = 1'b1;
                  push_job.kind = ugcb_pkg::JOB_IDENT;
               end else if (rx_byte == ugcb_pkg::CMD_READ) begin
                  push           = 1'b1;
                  push_job.kind  = ugcb_pkg::JOB_READ;
                  push_job.value = ~gathered;
               end else if (rx_byte == ugcb_pkg::CMD_WRITE) begin
                  count_in = ugcb_pkg::CNT_HIGH;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= ugcb_pkg::CNT_IDLE;
         data_high_ff <= 8'h00;
      end else begin
         count_ff     <= count_in;
         data_high_ff <= data_high_in;
      end
   end

endmodule

// ===== src/ugcb_queue.sv =====
// Short job queue between the front decoder and the back sequencer.
// Depends on ugcb_pkg for the job type.
module ugcb_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ugcb_pkg::job_type          push_job,
   input  logic                       pop,
   output logic                       full,
   output ugcb_pkg::queue_status_type status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ugcb_pkg::job_type slot_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full         = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head  = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/ugcb_back.sv =====
// Back sequencer: pops jobs and emits their result transactions through
// an output register. Depends on ugcb_pkg.
module ugcb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ugcb_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [7:0]                 tx_byte,
   output logic                       tx_valid,
   output logic [15:0]                port_value,
   output logic                       port_write,
   output logic                       last
);

   localparam logic [ugcb_pkg::STEP_W-1:0] IDENT_END = ugcb_pkg::STEP_W'(ugcb_pkg::IDENT_LEN);

   ugcb_pkg::back_state_type        state_ff, state_in;
   logic [ugcb_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [15:0]                     value_ff, value_in;
   logic                            out_valid_ff, out_valid_in;
   logic [7:0]                      tx_byte_ff, tx_byte_in;
   logic                            tx_valid_ff, tx_valid_in;
   logic [15:0]                     port_value_ff, port_value_in;
   logic                            port_write_ff, port_write_in;
   logic                            last_ff, last_in;
   logic                            load;

   // busy, and the output slot free or being emptied this cycle
   assign load = (state_ff != ugcb_pkg::BK_IDLE) && (!out_valid_ff || out_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      value_in = value_ff;
      pop      = 1'b0;
      case (state_ff)
         ugcb_pkg::BK_IDLE: begin
            if (!status.empty) begin
               pop      = 1'b1;
               step_in  = '0;
               value_in = status.head.value;
               case (status.head.kind)
                  ugcb_pkg::JOB_IDENT: state_in = ugcb_pkg::BK_IDENT;
                  ugcb_pkg::JOB_READ:  state_in = ugcb_pkg::BK_READ;
                  ugcb_pkg::JOB_WRITE: state_in = ugcb_pkg::BK_WRITE;
                  default:             state_in = ugcb_pkg::BK_IDLE;
               endcase
            end
         end
         ugcb_pkg::BK_IDENT: begin
            if (load) begin
               step_in = step_ff + ugcb_pkg::STEP_W'(1);
               if (step_ff == IDENT_END) begin
                  state_in = ugcb_pkg::BK_IDLE;
               end
            end
         end
         ugcb_pkg::BK_READ: begin
            if (load) begin
               step_in = step_ff + ugcb_pkg::STEP_W'(1);
               if (step_ff != '0) begin
                  state_in = ugcb_pkg::BK_IDLE;
               end
            end
         end
         ugcb_pkg::BK_WRITE: begin
            if (load) begin
               state_in = ugcb_pkg::BK_IDLE;
            end
         end
         default: state_in = ugcb_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      tx_byte_in    = tx_byte_ff;
      tx_valid_in   = tx_valid_ff;
      port_value_in = port_value_ff;
      port_write_in = port_write_ff;
      last_in       = last_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      if (load) begin
         out_valid_in  = 1'b1;
         tx_byte_in    = 8'h00;
         tx_valid_in   = 1'b0;
         port_value_in = 16'h0000;
         port_write_in = 1'b0;
         last_in       = 1'b0;
         case (state_ff)
            ugcb_pkg::BK_IDENT: begin
               tx_byte_in  = ugcb_pkg::ident_char(step_ff);
               tx_valid_in = 1'b1;
               last_in     = (step_ff == IDENT_END);
            end
            ugcb_pkg::BK_READ: begin
               tx_byte_in  = (step_ff == '0) ? value_ff[15:8] : value_ff[7:0];
               tx_valid_in = 1'b1;
               last_in     = (step_ff != '0);
            end
            ugcb_pkg::BK_WRITE: begin
               port_value_in = value_ff;
               port_write_in = 1'b1;
               last_in       = 1'b1;
            end
            default: out_valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ugcb_pkg::BK_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      tx_byte_ff    <= tx_byte_in;
      tx_valid_ff   <= tx_valid_in;
      port_value_ff <= port_value_in;
      port_write_ff <= port_write_in;
      last_ff       <= last_in;
   end

   assign out_valid  = out_valid_ff;
   assign tx_byte    = tx_byte_ff;
   assign tx_valid   = tx_valid_ff;
   assign port_value = port_value_ff;
   assign port_write = port_write_ff;
   assign last       = last_ff;

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (tx_valid_ff != port_write_ff))
      else $error("result is neither or both of transmit and port write");

   a_write_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && port_write_ff) |-> last_ff)
      else $error("port write result not marked last");

   a_ident_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ugcb_pkg::BK_IDENT) |-> (step_ff <= IDENT_END))
      else $error("identification step past end of text");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff != ugcb_pkg::BK_IDLE))
      else $error("job popped but sequencer stayed idle");

   a_read_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ugcb_pkg::BK_READ) |-> (step_ff <= ugcb_pkg::STEP_W'(1)))
      else $error("read reply step out of range");

endmodule

// ===== src/uart_gpio_command_bridge.sv =====
// Top level of the UART command bridge: front decoder, job queue, back sequencer.
// Depends on ugcb_pkg, ugcb_front, ugcb_queue and ugcb_back.
//
//  channel | dir | handshake          | contents
//  req     | in  | req_tvalid/tready  | tdata: rx_byte, pins_b, pins_a, pins_e
//  rsp     | out | rsp_tvalid/tready  | tdata: tx_byte, port_value; tuser: flags; tlast
//
// A received byte is taken every cycle while the job queue has room.
// The sequencer pops a job while idle, then emits its results in order, waiting while
// rsp is stalled: identify gives 14, read 2, write 1; other bytes produce no job.
// Reset clears the frame counter, the queue pointers, the sequencer and
// the output valid. A stalled rsp side fills the queue (QUEUE_DEPTH jobs),
// then req_tready drops.
module uart_gpio_command_bridge #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // rx_byte[7:0], pins_b[23:8], pins_a[39:24], pins_e[55:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte[7:0], port_value[23:8]
   output logic [1:0]  rsp_tuser,   // tx_valid[0], port_write[1]
   output logic        rsp_tlast
);

   logic                       push;
   ugcb_pkg::job_type          push_job;
   logic                       pop;
   logic                       full;
   ugcb_pkg::queue_status_type status;
   logic [7:0]                 tx_byte;
   logic                       tx_valid;
   logic [15:0]                port_value;
   logic                       port_write;

   assign req_tready = !full;

   ugcb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .rx_byte  (req_tdata[7:0]),
      .pins_b   (req_tdata[23:8]),
      .pins_a   (req_tdata[39:24]),
      .pins_e   (req_tdata[55:40]),
      .push     (push),
      .push_job (push_job)
   );

   ugcb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .status   (status)
   );

   ugcb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .tx_byte    (tx_byte),
      .tx_valid   (tx_valid),
      .port_value (port_value),
      .port_write (port_write),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = {port_value, tx_byte};
   assign rsp_tuser = {port_write, tx_valid};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for uart_gpio_command_bridge: identify, port read, port write and
// unknown commands, checked against an in-bench model of the command decoder. Depends on ugcb_pkg.
module testbench;

   localparam int DRAIN_CYCLES = 40;
   // identification text, first character in the top byte
   localparam logic [103:0] ID_TEXT = 104'h534F333731352D31482E313130;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic [15:0] port_value;
      logic        port_write;
      logic        last_flag;
   } bridge_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // rx_byte, pins_b, pins_a, pins_e
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // tx_byte, port_value
   logic [1:0]  rsp_tuser;        // tx_valid, port_write
   logic        rsp_tlast;

   // decoder model state
   logic [1:0]  frame_pos = ugcb_pkg::CNT_IDLE;
   logic [7:0]  held_high = '0;
   logic [7:0]  last_command = '0;

   bridge_reply_type reply_q[$];
   int          mismatch_count = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          rsp_hold = 0;

   uart_gpio_command_bridge dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic int gap_draw(input bit calm);
      return calm ? 0 : int'($urandom_range(8, 0));
   endfunction

   function automatic bridge_reply_type make_reply(input logic [7:0] tx, input logic txv,
                                                   input logic [15:0] pv, input logic pw,
                                                   input logic lst);
      bridge_reply_type r;
      r.tx_byte    = tx;
      r.tx_valid   = txv;
      r.port_value = pv;
      r.port_write = pw;
      r.last_flag  = lst;
      return r;
   endfunction

   function automatic logic [15:0] inverted_pins(input logic [15:0] pb, input logic [15:0] pa,
                                                 input logic [15:0] pe);
      logic [15:0] w;
      w = {pb[13:10], pa[7:4], pe[0], pb[9:3]};
      return ~w;
   endfunction

   task automatic predict_reply(input logic [7:0] rx, input logic [15:0] pb,
                                input logic [15:0] pa, input logic [15:0] pe);
      logic [15:0] w;
      if (frame_pos == ugcb_pkg::CNT_HIGH) begin
         held_high = rx;
         frame_pos = ugcb_pkg::CNT_LOW;
      end else if (frame_pos == ugcb_pkg::CNT_LOW) begin
         frame_pos = ugcb_pkg::CNT_IDLE;
         reply_q.push_back(make_reply(8'h00, 1'b0, ~{held_high, rx}, 1'b1, 1'b1));
      end else begin
         // idle, and the unreachable fourth count value, take the byte as a command
         frame_pos = ugcb_pkg::CNT_IDLE;
         last_command = rx;
         if (rx == ugcb_pkg::CMD_IDENT) begin
            for (int i = 0; i < ugcb_pkg::IDENT_LEN; i++)
               reply_q.push_back(make_reply(ID_TEXT[103 - 8 * i -: 8], 1'b1, 16'h0000,
                                            1'b0, 1'b0));
            reply_q.push_back(make_reply(8'h00, 1'b1, 16'h0000, 1'b0, 1'b1));
         end else if (rx == ugcb_pkg::CMD_READ) begin
            w = inverted_pins(pb, pa, pe);
            reply_q.push_back(make_reply(w[15:8], 1'b1, 16'h0000, 1'b0, 1'b0));
            reply_q.push_back(make_reply(w[7:0], 1'b1, 16'h0000, 1'b0, 1'b1));
         end else if (rx == ugcb_pkg::CMD_WRITE) begin
            frame_pos = ugcb_pkg::CNT_HIGH;
         end
      end
   endtask

   // one input transaction; returns at the accepting edge with tvalid still high
   task automatic send_item(input logic [7:0] rx, input logic [15:0] pb,
                            input logic [15:0] pa, input logic [15:0] pe);
      int gap;
      gap = gap_draw(req_calm);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {pe, pa, pb, rx};
      do @(posedge clock); while (!req_tready);
      predict_reply(rx, pb, pa, pe);
   endtask

   task automatic send_byte(input logic [7:0] rx);
      send_item(rx, 16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
                16'($urandom_range(16'hFFFF, 0)));
   endtask

   task automatic send_port_write(input logic [7:0] high, input logic [7:0] low);
      send_byte(ugcb_pkg::CMD_WRITE);
      send_byte(high);
      send_byte(low);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
      // bytes without a reply may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : reply_checker
      bridge_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (reply_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, %s tdata=%h tuser=%b tlast=%b",
                     $time, "actual", rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = reply_q.pop_front();
            check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_tdata[7:0]));
            check_field("tx_valid", 16'(want.tx_valid), 16'(rsp_tuser[0]));
            check_field("port_value", want.port_value, rsp_tdata[23:8]);
            check_field("port_write", 16'(want.port_write), 16'(rsp_tuser[1]));
            check_field("tlast", 16'(want.last_flag), 16'(rsp_tlast));
         end
      end
   end

   always begin : rsp_side
      int pause;
      pause = (rsp_hold > 0) ? rsp_hold : gap_draw(rsp_calm);
      rsp_hold = 0;
      repeat (pause) begin
         @(negedge clock);
         rsp_tready <= 1'b0;
      end
      @(negedge clock);
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!rsp_tvalid);
   end

   task automatic test_ident();
      send_byte(ugcb_pkg::CMD_IDENT);
      send_byte(ugcb_pkg::CMD_IDENT);
   endtask

   task automatic test_read_extremes();
      send_item(ugcb_pkg::CMD_READ, 16'h0000, 16'h0000, 16'h0000);
      send_item(ugcb_pkg::CMD_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // only the gathered bits set, then only the ignored ones
      send_item(ugcb_pkg::CMD_READ, 16'h3FF8, 16'h00F0, 16'h0001);
      send_item(ugcb_pkg::CMD_READ, 16'hC007, 16'hFF0F, 16'hFFFE);
   endtask

   task automatic test_write_extremes();
      send_port_write(8'h00, 8'h00);
      send_port_write(8'hFF, 8'hFF);
      // data bytes equal to command codes are plain data
      send_port_write(ugcb_pkg::CMD_WRITE, ugcb_pkg::CMD_IDENT);
      send_port_write(ugcb_pkg::CMD_READ, ugcb_pkg::CMD_WRITE);
   endtask

   task automatic test_unknown_commands();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h03);
      send_byte(8'hB8);
      send_byte(8'hBB);
      send_byte(ugcb_pkg::CMD_READ);
      wait_drained();
   endtask

   task automatic test_back_pressure();
      wait_drained();
      rsp_hold = 300;
      req_calm = 1'b1;
      repeat (6) begin
         send_byte(ugcb_pkg::CMD_IDENT);
         send_byte(ugcb_pkg::CMD_READ);
      end
      req_calm = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int sent;
      int pick;
      logic [7:0] noise;
      sent = 0;
      while (sent < 130) begin
         req_calm = (sent >= 40 && sent < 70);
         rsp_calm = req_calm;
         pick = int'($urandom_range(99, 0));
         if (pick < 30) begin
            send_byte(ugcb_pkg::CMD_READ);
            sent++;
         end else if (pick < 42) begin
            send_byte(ugcb_pkg::CMD_IDENT);
            sent++;
         end else if (pick < 72) begin
            send_port_write(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
            sent += 3;
         end else if (pick < 88) begin
            do noise = 8'($urandom_range(255, 0));
            while (noise == ugcb_pkg::CMD_IDENT || noise == ugcb_pkg::CMD_READ ||
                   noise == ugcb_pkg::CMD_WRITE);
            send_byte(noise);
            sent++;
         end else if (pick < 95) begin
            send_port_write(($urandom_range(1, 0) != 0) ? ugcb_pkg::CMD_IDENT
                                                          : ugcb_pkg::CMD_WRITE,
                            ($urandom_range(1, 0) != 0) ? ugcb_pkg::CMD_READ
                                                          : ugcb_pkg::CMD_WRITE);
            sent += 3;
         end else begin
            wait_drained();
         end
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_ident();
      test_read_extremes();
      test_write_extremes();
      test_unknown_commands();
      test_back_pressure();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/ugcb_pkg.sv
src/ugcb_front.sv
src/ugcb_queue.sv
src/ugcb_back.sv
src/uart_gpio_command_bridge.sv
tb/sv/testbench.sv
